@@ rtl/hbe_pkg.sv @@
// Shared widths, operation codes and the stage record of the Hermite basis evaluator.
package hbe_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned POS_W     = 18;
  localparam int unsigned ZW        = FRAC_BITS;      // z in [0, 1)
  localparam int unsigned UW        = FRAC_BITS + 1;  // u in (0, 1]
  localparam int unsigned ACC_W     = FRAC_BITS + 4;  // largest factor is below 10
  localparam int unsigned XW        = ACC_W;
  localparam int unsigned YW        = FRAC_BITS + 2;  // 3z + 1 is below 4
  localparam int unsigned MAG_W     = ACC_W + 5;      // room for the factor 30
  localparam int unsigned NUM_CELLS = 3;

  localparam logic [ACC_W-1:0] ONE_ACC  = ACC_W'(1) << FRAC_BITS;
  localparam logic [POS_W-1:0] ONE_POS  = POS_W'(1) << FRAC_BITS;
  localparam logic [UW-1:0]    ONE_U    = UW'(1) << FRAC_BITS;
  localparam logic [MAG_W-1:0] MAX_MAG  = MAG_W'((1 << (POS_W - 1)) - 1);

  typedef logic [2:0] op_t;
  localparam op_t OP_PASS   = 3'd0;  // hold acc
  localparam op_t OP_ZZ     = 3'd1;  // acc = z * z
  localparam op_t OP_ZW     = 3'd2;  // acc = z * (3z + 1)
  localparam op_t OP_PW_LIN = 3'd3;  // acc = (2z + 1) * pw
  localparam op_t OP_PW_Z   = 3'd4;  // acc = z * pw
  localparam op_t OP_POLY   = 3'd5;  // acc = 6 acc + 3z + 1
  localparam op_t OP_PW_ACC = 3'd6;  // acc = acc * pw

  typedef enum logic [2:0] {
    SC_U,
    SC_1,
    SC_5,
    SC_6,
    SC_30
  } scale_e;

  typedef struct packed {
    logic [ZW-1:0]             z;
    logic [UW-1:0]             u;
    logic [UW-1:0]             pw;
    logic [ACC_W-1:0]          acc;
    op_t [NUM_CELLS-1:0]       prog;
    scale_e                    scale;
    logic                      neg_odd;
    logic                      in_support;
    logic                      bad;
  } hbe_data_t;

  // Round a scaled product to nearest, ties up, and drop the fraction.
  function automatic logic [ACC_W-1:0] fx_round(input logic [XW+YW-1:0] prod);
    logic [XW+YW-1:0] s;
    s = prod + (XW + YW)'(1 << (FRAC_BITS - 1));
    return s[FRAC_BITS +: ACC_W];
  endfunction

endpackage

@@ rtl/hbe_cell.sv @@
// One cell of the evaluator chain: one power step of u and one operation on acc.
module hbe_cell
  import hbe_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  hbe_data_t in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output hbe_data_t out_data_o
);

  logic      valid_q, valid_d;
  hbe_data_t data_q, data_d;
  logic [XW-1:0]    x_op;
  logic [YW-1:0]    y_op;
  logic [XW+YW-1:0] prod;
  logic [2*UW-1:0]  pw_prod;
  logic [YW-1:0]    z_y;
  logic [XW-1:0]    z_x;
  op_t              op;

  assign in_ready_o = !valid_q || out_ready_i;
  assign op         = in_data_i.prog[0];

  always_comb begin
    z_y = YW'(in_data_i.z);
    z_x = XW'(in_data_i.z);
    x_op = '0;
    y_op = '0;
    unique case (op)
      OP_ZZ: begin
        x_op = z_x;
        y_op = z_y;
      end
      OP_ZW: begin
        x_op = z_x;
        y_op = (z_y << 1) + z_y + YW'(ONE_ACC);
      end
      OP_PW_LIN: begin
        x_op = (z_x << 1) + XW'(ONE_ACC);
        y_op = YW'(in_data_i.pw);
      end
      OP_PW_Z: begin
        x_op = z_x;
        y_op = YW'(in_data_i.pw);
      end
      OP_PW_ACC: begin
        x_op = XW'(in_data_i.acc);
        y_op = YW'(in_data_i.pw);
      end
      default: begin
        x_op = '0;
        y_op = '0;
      end
    endcase
    prod    = (XW + YW)'(x_op) * (XW + YW)'(y_op);
    pw_prod = in_data_i.pw * in_data_i.u;
  end

  always_comb begin
    data_d    = in_data_i;
    data_d.pw = UW'(fx_round((XW + YW)'(pw_prod)));
    unique case (op)
      OP_PASS: data_d.acc = in_data_i.acc;
      OP_POLY: data_d.acc = (in_data_i.acc << 2) + (in_data_i.acc << 1)
                            + (ACC_W'(in_data_i.z) << 1) + ACC_W'(in_data_i.z) + ONE_ACC;
      OP_ZZ, OP_ZW, OP_PW_LIN, OP_PW_Z, OP_PW_ACC: data_d.acc = fx_round(prod);
      default: data_d.acc = in_data_i.acc;
    endcase
    // advance the program by one slot
    for (int k = 0; k < NUM_CELLS - 1; k++) begin
      data_d.prog[k] = in_data_i.prog[k+1];
    end
    data_d.prog[NUM_CELLS-1] = OP_PASS;
  end

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !out_ready_i |=> valid_q && $stable(data_q))
    else $error("cell dropped or changed a stalled item");

  a_last_slot_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> data_q.prog[NUM_CELLS-1] == OP_PASS)
    else $error("program slot not refilled with pass");

  a_bad_no_ops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && data_q.bad |-> data_q.prog[0] == OP_PASS && data_q.acc == '0)
    else $error("invalid request carries work");

endmodule

@@ rtl/hbe_finish.sv @@
// Output stage: scale, saturate, apply the sign and register the result.
module hbe_finish
  import hbe_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  hbe_data_t        in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [POS_W-1:0] value_o,
  output logic             bad_o
);

  logic             valid_q;
  logic [POS_W-1:0] value_q, value_d;
  logic             bad_q;
  logic [MAG_W-1:0] acc_w, mag;
  logic [POS_W-2:0] sat;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    acc_w = MAG_W'(in_data_i.acc);
    unique case (in_data_i.scale)
      SC_U:    mag = MAG_W'(in_data_i.u);
      SC_1:    mag = acc_w;
      SC_5:    mag = (acc_w << 2) + acc_w;
      SC_6:    mag = (acc_w << 2) + (acc_w << 1);
      SC_30:   mag = (acc_w << 5) - (acc_w << 1);
      default: mag = acc_w;
    endcase
    sat = (mag > MAX_MAG) ? MAX_MAG[POS_W-2:0] : mag[POS_W-2:0];
    value_d = in_data_i.neg_odd ? (POS_W'(0) - {1'b0, sat}) : {1'b0, sat};
    if (!in_data_i.in_support || in_data_i.bad) begin
      value_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      value_q <= value_d;
      bad_q   <= in_data_i.bad;
    end
  end

  assign out_valid_o = valid_q;
  assign value_o     = value_q;
  assign bad_o       = bad_q;

  a_bad_gives_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && bad_q |-> value_q == '0)
    else $error("invalid request with nonzero value");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !out_ready_i |=> valid_q && $stable(value_q) && $stable(bad_q))
    else $error("stalled result changed");

  a_take_on_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q |-> in_ready_o)
    else $error("empty output stage refuses a transfer");

endmodule

@@ rtl/hermite_basis_evaluator.sv @@
// Top level of the Hermite basis evaluator: input decode, cell chain and output stage.
// Each input transfer passes through the three registered cells of the chain, each
// with one rounding multiplier and one u power step, then the output register.
// Throughput: one item per cycle while out_ready_i is high; every stage holds one item
// and frees its slot when the next stage takes it; an empty stage accepts in a stall.
// Reset clears the valid bit of every stage; payload registers are not reset.
module hermite_basis_evaluator
  import hbe_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              continuity_i,
  input  logic [1:0]              basis_index_i,
  input  logic signed [POS_W-1:0] position_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [POS_W-1:0] value_o,
  output logic                    bad_request_o
);

  // Decode of the incoming request. Each cell executes the first slot of the
  // program and shifts the rest down; u^(k+1) sits in pw at the entry of cell k.
  logic [POS_W-1:0] pos_raw;
  logic [POS_W-1:0] mag;
  logic             neg;
  logic             invalid;
  hbe_data_t        entry;

  always_comb begin
    pos_raw = position_i;
    neg     = pos_raw[POS_W-1];
    mag     = neg ? (POS_W'(0) - pos_raw) : pos_raw;
    invalid = (continuity_i == 2'd3) || (basis_index_i > continuity_i);

    entry.z          = mag[ZW-1:0];
    entry.u          = ONE_U - UW'(mag[ZW-1:0]);
    entry.pw         = ONE_U - UW'(mag[ZW-1:0]);
    entry.acc        = '0;
    entry.in_support = (mag < ONE_POS);
    entry.bad        = (mag < ONE_POS) && invalid;
    entry.neg_odd    = neg && basis_index_i[0];
    entry.prog       = {OP_PASS, OP_PASS, OP_PASS};
    entry.scale      = SC_1;

    if (!invalid) begin
      unique case ({continuity_i, basis_index_i})
        {2'd0, 2'd0}: begin
          entry.scale = SC_U;
        end
        {2'd1, 2'd0}: begin
          entry.prog = {OP_PASS, OP_PW_LIN, OP_PASS};
        end
        {2'd1, 2'd1}: begin
          entry.prog  = {OP_PASS, OP_PW_Z, OP_PASS};
          entry.scale = SC_6;
        end
        {2'd2, 2'd0}: begin
          entry.prog = {OP_PW_ACC, OP_POLY, OP_ZZ};
        end
        {2'd2, 2'd1}: begin
          entry.prog  = {OP_PW_ACC, OP_PASS, OP_ZW};
          entry.scale = SC_5;
        end
        {2'd2, 2'd2}: begin
          entry.prog  = {OP_PW_ACC, OP_PASS, OP_ZZ};
          entry.scale = SC_30;
        end
        default: begin
          entry.prog  = {OP_PASS, OP_PASS, OP_PASS};
          entry.scale = SC_1;
        end
      endcase
    end
  end

  // Cell chain: stage k feeds stage k+1, ready travels back.
  hbe_data_t stage_data  [NUM_CELLS+1];
  logic      stage_valid [NUM_CELLS+1];
  logic      stage_ready [NUM_CELLS+1];

  assign stage_data[0]  = entry;
  assign stage_valid[0] = in_valid_i;
  assign in_ready_o     = stage_ready[0];

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    hbe_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (stage_valid[k]),
      .in_ready_o  (stage_ready[k]),
      .in_data_i   (stage_data[k]),
      .out_valid_o (stage_valid[k+1]),
      .out_ready_i (stage_ready[k+1]),
      .out_data_o  (stage_data[k+1])
    );
  end

  // Scale, saturate, sign and hold the result until its transfer.
  logic [POS_W-1:0] value_raw;

  hbe_finish u_finish (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (stage_valid[NUM_CELLS]),
    .in_ready_o  (stage_ready[NUM_CELLS]),
    .in_data_i   (stage_data[NUM_CELLS]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_raw),
    .bad_o       (bad_request_o)
  );

  assign value_o = signed'(value_raw);

endmodule
